FILE: rtl/jse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jse_pkg: shared types, constants and functions of the JSON string escaper
// Holds the channel payload structs, the job format queued between the front
// and back ends, the character constants and the UTF-8 classification helpers.
// ----------------------------------------------------------------------------
package jse_pkg;

    // Depth of the job queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    // One input byte produces at most this many output units.
    localparam int MAX_UNITS  = 4;
    localparam int UNIT_IDX_W = $clog2(MAX_UNITS);
    localparam int UNIT_CNT_W = $clog2(MAX_UNITS + 1);
    localparam int CHAR_IDX_W = 3;

    // Characters that the escaper writes.
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;

    // UTF-8 bounds (RFC 3629).
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_LO     = 8'hC2;
    localparam logic [7:0] LEAD2_HI     = 8'hDF;
    localparam logic [7:0] LEAD3_LO     = 8'hE0;
    localparam logic [7:0] LEAD3_HI     = 8'hEF;
    localparam logic [7:0] LEAD4_LO     = 8'hF0;
    localparam logic [7:0] LEAD4_HI     = 8'hF4;
    localparam logic [7:0] LEAD_E0      = 8'hE0;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_F0      = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;
    localparam logic [7:0] CONT_LO      = 8'h80;
    localparam logic [7:0] CONT_HI      = 8'hBF;
    localparam logic [7:0] E0_SECOND_LO = 8'hA0;
    localparam logic [7:0] ED_SECOND_HI = 8'h9F;
    localparam logic [7:0] F0_SECOND_LO = 8'h90;
    localparam logic [7:0] F4_SECOND_HI = 8'h8F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } out_item_t;

    // How one byte is rendered on the output.
    typedef enum logic [1:0] {
        UK_PASS,    // the byte itself
        UK_QUOTE,   // backslash, byte
        UK_CTRL,    // backslash, u, 0, 0, two hex digits
        UK_HEX      // two backslashes, x, two hex digits
    } unit_kind_t;

    typedef struct packed {
        unit_kind_t kind;
        logic [7:0] value;
    } unit_t;

    // Everything one input byte causes on the output.
    typedef struct packed {
        unit_t [MAX_UNITS-1:0]   units;
        logic  [UNIT_CNT_W-1:0]  unit_count;
        logic                    end_of_text;
    } job_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOWER_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            len = 3'd2;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            len = 3'd3;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

    function automatic logic second_byte_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (lead == LEAD_E0) lo = E0_SECOND_LO;
        if (lead == LEAD_ED) hi = ED_SECOND_HI;
        if (lead == LEAD_F0) lo = F0_SECOND_LO;
        if (lead == LEAD_F4) hi = F4_SECOND_HI;
        return (b >= lo) && (b <= hi);
    endfunction

    // Rendering of a byte that does not start a sequence.
    function automatic unit_kind_t fresh_kind(input logic [7:0] b);
        unit_kind_t k;
        if (b == CH_QUOTE || b == CH_BACKSLASH) begin
            k = UK_QUOTE;
        end else if (b < CTRL_LIMIT) begin
            k = UK_CTRL;
        end else if (b < ASCII_LIMIT) begin
            k = UK_PASS;
        end else begin
            k = UK_HEX;
        end
        return k;
    endfunction

    function automatic logic [CHAR_IDX_W-1:0] unit_length(input unit_kind_t k);
        logic [CHAR_IDX_W-1:0] len;
        case (k)
            UK_PASS:  len = 3'd1;
            UK_QUOTE: len = 3'd2;
            UK_CTRL:  len = 3'd6;
            UK_HEX:   len = 3'd5;
            default:  len = 3'd1;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/jse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jse_front: input classification and UTF-8 sequence tracking
// Takes one byte per cycle while the job queue has room, tracks the pending
// UTF-8 sequence and turns bytes into back-end jobs of up to four output units.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     q_full,
    output logic          q_push,
    output job_t          q_job
);

    logic [7:0] pend_reg  [3];
    logic [7:0] pend_next [3];
    logic [1:0] pcount_reg, pcount_next;
    logic [2:0] seqlen_reg, seqlen_next;

    logic                  in_fire;
    logic [7:0]            b;
    logic                  seq_ok;
    logic                  take_fresh;
    logic [UNIT_CNT_W-1:0] n;
    logic [2:0]            lead_len;

    assign s_ready  = !q_full;
    assign in_fire  = s_valid && s_ready;
    assign b        = s_item.data_byte;
    assign lead_len = lead_length(b);

    always_comb begin
        pend_next   = pend_reg;
        pcount_next = pcount_reg;
        seqlen_next = seqlen_reg;
        q_job       = '0;
        n           = '0;
        seq_ok      = 1'b0;
        take_fresh  = 1'b0;

        if (in_fire) begin
            if (pcount_reg == 2'd0) begin
                take_fresh = 1'b1;
            end else begin
                seq_ok = (pcount_reg == 2'd1) ? second_byte_ok(pend_reg[0], b)
                                              : (b[7:6] == 2'b10);
                if (seq_ok) begin
                    if ({1'b0, pcount_reg} + 3'd1 >= seqlen_reg) begin
                        // Sequence complete: pass all held bytes and this one.
                        for (int k = 0; k < 3; k++) begin
                            if (2'(k) < pcount_reg) begin
                                q_job.units[n[UNIT_IDX_W-1:0]] = '{UK_PASS, pend_reg[k]};
                                n = n + 1'b1;
                            end
                        end
                        q_job.units[n[UNIT_IDX_W-1:0]] = '{UK_PASS, b};
                        n = n + 1'b1;
                        pcount_next = 2'd0;
                        seqlen_next = 3'd0;
                    end else begin
                        pend_next[pcount_reg] = b;
                        pcount_next = pcount_reg + 2'd1;
                    end
                end else begin
                    // Broken sequence: escape the held bytes, then start over.
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < pcount_reg) begin
                            q_job.units[n[UNIT_IDX_W-1:0]] = '{UK_HEX, pend_reg[k]};
                            n = n + 1'b1;
                        end
                    end
                    pcount_next = 2'd0;
                    seqlen_next = 3'd0;
                    take_fresh  = 1'b1;
                end
            end

            if (take_fresh) begin
                if (lead_len != 3'd0) begin
                    pend_next[0] = b;
                    pcount_next  = 2'd1;
                    seqlen_next  = lead_len;
                end else begin
                    q_job.units[n[UNIT_IDX_W-1:0]] = '{fresh_kind(b), b};
                    n = n + 1'b1;
                end
            end

            // End of text flushes whatever is still held.
            if (s_item.end_of_text && pcount_next != 2'd0) begin
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < pcount_next) begin
                        q_job.units[n[UNIT_IDX_W-1:0]] = '{UK_HEX, pend_next[k]};
                        n = n + 1'b1;
                    end
                end
                pcount_next = 2'd0;
                seqlen_next = 3'd0;
            end
        end

        q_job.unit_count  = n;
        q_job.end_of_text = s_item.end_of_text;
    end

    assign q_push = in_fire && (n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg <= 2'd0;
            seqlen_reg <= 3'd0;
        end else begin
            pcount_reg <= pcount_next;
            seqlen_reg <= seqlen_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    a_held_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        pcount_reg != 2'd0 |-> seqlen_reg > {1'b0, pcount_reg})
        else $error("held byte count not below sequence length");

    a_eot_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_item.end_of_text) |=> pcount_reg == 2'd0)
        else $error("bytes still held after end of text");

endmodule
`default_nettype wire

FILE: rtl/jse_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jse_queue: job queue between front end and back end
// A small first-in first-out buffer of jobs with a combinational head.
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("job pushed into a full queue");

endmodule
`default_nettype wire

FILE: rtl/jse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jse_back: output expansion
// Walks the head job unit by unit, char by char, producing one escaped byte per
// cycle into the output register while a job waits and the consumer takes it.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    input  wire job_t  q_job,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_item_t  m_item
);

    logic [UNIT_IDX_W-1:0] unit_idx_reg, unit_idx_next;
    logic [CHAR_IDX_W-1:0] char_idx_reg, char_idx_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_item_reg, m_item_next;

    unit_t                 cur;
    logic [CHAR_IDX_W-1:0] cur_len;
    logic                  char_last;
    logic                  unit_last;
    logic                  load;
    logic [7:0]            ch;

    assign cur       = q_job.units[unit_idx_reg];
    assign cur_len   = unit_length(cur.kind);
    assign char_last = (char_idx_reg == cur_len - 1'b1);
    assign unit_last = (UNIT_CNT_W'(unit_idx_reg) == q_job.unit_count - 1'b1);
    assign load      = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        ch = cur.value;
        case (cur.kind)
            UK_PASS: begin
                ch = cur.value;
            end
            UK_QUOTE: begin
                ch = (char_idx_reg == 3'd0) ? CH_BACKSLASH : cur.value;
            end
            UK_CTRL: begin
                case (char_idx_reg)
                    3'd0:    ch = CH_BACKSLASH;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = CH_ZERO;
                    3'd3:    ch = CH_ZERO;
                    3'd4:    ch = hex_digit(cur.value[7:4]);
                    default: ch = hex_digit(cur.value[3:0]);
                endcase
            end
            UK_HEX: begin
                case (char_idx_reg)
                    3'd0:    ch = CH_BACKSLASH;
                    3'd1:    ch = CH_BACKSLASH;
                    3'd2:    ch = CH_X;
                    3'd3:    ch = hex_digit(cur.value[7:4]);
                    default: ch = hex_digit(cur.value[3:0]);
                endcase
            end
            default: begin
                ch = cur.value;
            end
        endcase
    end

    always_comb begin
        unit_idx_next = unit_idx_reg;
        char_idx_next = char_idx_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        q_pop         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            m_valid_next            = 1'b1;
            m_item_next.out_byte    = ch;
            m_item_next.last_of_run = char_last && unit_last;
            m_item_next.text_done   = char_last && unit_last && q_job.end_of_text;
            if (char_last) begin
                char_idx_next = '0;
                if (unit_last) begin
                    unit_idx_next = '0;
                    q_pop         = 1'b1;
                end else begin
                    unit_idx_next = unit_idx_reg + 1'b1;
                end
            end else begin
                char_idx_next = char_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_idx_reg <= '0;
            char_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            unit_idx_reg <= unit_idx_next;
            char_idx_reg <= char_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_unit_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (q_job.unit_count != '0) &&
                    (UNIT_CNT_W'(unit_idx_reg) < q_job.unit_count))
        else $error("unit index outside the head job");

    a_char_in_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> char_idx_reg < cur_len)
        else $error("character index outside the current unit");

    a_pop_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid && m_item.last_of_run)
        else $error("job retired without marking the end of its run");

endmodule
`default_nettype wire

FILE: rtl/json_string_escape_utf8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_escape_utf8: JSON string escaper with strict UTF-8 validation
// Escapes a byte stream for a JSON string and checks UTF-8 sequences.
// ----------------------------------------------------------------------------
// The block takes one text byte per transfer on the s_ channel and gives the
// escaped text one byte per transfer on the m_ channel. A quote or backslash
// gets a leading backslash, a control byte becomes a \u00xx escape, and other
// ASCII bytes pass unchanged. A well-formed UTF-8 sequence is held until it
// completes and then passes whole; an ill-formed or cut-off sequence has each
// held byte written as \\x followed by two lower-case hex digits. last_of_run
// marks the final output byte caused by an input byte, and text_done marks
// the final output byte of an input that carries end_of_text. A byte that only
// extends a pending sequence produces no output. The front end accepts one
// input byte every cycle while its job queue has room, and the back end sends
// one output byte every cycle a job waits and the consumer takes it; an input
// byte expands into zero to twenty-one output bytes, and the output rate of one
// byte per cycle of the back end sets the sustained throughput.
// Between an input transfer and its first output byte lie the job queue and the
// output register: the job enters the queue at the transfer edge, and the output
// register loads the first byte once the job heads the queue and the register is free.
// ----------------------------------------------------------------------------
module json_string_escape_utf8 import jse_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    // Jobs travel from the front end to the back end through the queue.
    logic q_full;
    logic q_push;
    job_t q_push_job;
    logic q_pop;
    logic q_head_valid;
    job_t q_head_job;

    // The front end classifies each byte and tracks the pending sequence.
    jse_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (q_push_job)
    );

    // The queue lets the front end keep accepting while the back end expands.
    jse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    // The back end renders each job into output bytes under backpressure.
    jse_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_head_valid),
        .q_job   (q_head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire
